@@ rtl/sfd_pkg.sv @@
// shared types and constants for the sync frame sample deframer with comb notch
// no dependencies
package sfd_pkg;

  localparam int CHAN_W     = 4;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  localparam logic [7:0]  HDR_FIRST      = 8'h55;
  localparam logic [7:0]  HDR_SECOND     = 8'hAA;
  localparam logic [15:0] SIGN_THRESHOLD = 16'd32767;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_END    = 1'b1;

  localparam logic [1:0] REG_B_NOW    = 2'd0;
  localparam logic [1:0] REG_B_DELAY  = 2'd1;
  localparam logic [1:0] REG_A_DELAY  = 2'd2;
  localparam logic [1:0] REG_OFFSET   = 2'd3;

  localparam logic signed [17:0] B_NOW_RST   = 18'sd59304;
  localparam logic signed [17:0] B_DELAY_RST = -18'sd59304;
  localparam logic signed [17:0] A_DELAY_RST = -18'sd53070;
  localparam logic [11:0]        OFFSET_RST  = 12'd1862;

  typedef struct packed {
    logic                kind;
    logic [CHAN_W-1:0]   ch;
    logic signed [16:0]  x;
    logic                ok;
  } sfd_item_t;

  typedef struct packed {
    logic signed [17:0] b_now;
    logic signed [17:0] b_delay;
    logic signed [17:0] a_delay;
  } sfd_coef_t;

endpackage

@@ rtl/sfd_front.sv @@
// front end: header hunt, sample assembly, checksum and channel rotation
// depends on sfd_pkg
module sfd_front #(
  parameter int CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic [11:0]        offset,
  output logic               push,
  output sfd_pkg::sfd_item_t push_item
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W = $clog2(2 * CHANNELS);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_HDR2 = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_SUM  = 2'd3;

  logic [1:0]       phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       hold_r, hold_nxt;
  logic [CH_W-1:0]  rot_r, rot_nxt;
  logic             accept;
  logic [15:0]      raw;
  logic [16:0]      signed_val;
  logic [16:0]      x_val;

  assign accept     = in_valid && !in_stall;
  assign raw        = {hold_r, in_rx_byte};
  assign signed_val = (raw >= sfd_pkg::SIGN_THRESHOLD) ? {1'b1, raw} : {1'b0, raw};
  assign x_val      = signed_val - {5'b0, offset};

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    hold_nxt  = hold_r;
    rot_nxt   = rot_r;
    push      = 1'b0;
    push_item = '0;
    if (accept) begin
      case (phase_r)
        PH_HUNT: begin
          if (in_rx_byte == sfd_pkg::HDR_FIRST) begin
            phase_nxt = PH_HDR2;
          end
        end
        PH_HDR2: begin
          if (in_rx_byte == sfd_pkg::HDR_SECOND) begin
            phase_nxt = PH_DATA;
            pos_nxt   = '0;
            sum_nxt   = '0;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_DATA: begin
          sum_nxt = sum_r + in_rx_byte;
          if (!pos_r[0]) begin
            hold_nxt = in_rx_byte;
          end else begin
            rot_nxt        = (rot_r == CH_W'(CHANNELS - 1)) ? '0 : rot_r + 1'b1;
            push           = 1'b1;
            push_item.kind = sfd_pkg::KIND_SAMPLE;
            push_item.ch   = sfd_pkg::CHAN_W'(rot_nxt);
            push_item.x    = x_val;
            push_item.ok   = 1'b0;
          end
          pos_nxt = pos_r + 1'b1;
          if (pos_r == POS_W'(2 * CHANNELS - 1)) begin
            phase_nxt = PH_SUM;
          end
        end
        default: begin
          push           = 1'b1;
          push_item.kind = sfd_pkg::KIND_END;
          push_item.ok   = (sum_r == in_rx_byte);
          phase_nxt      = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= '0;
      sum_r   <= '0;
      hold_r  <= '0;
      rot_r   <= CH_W'(CHANNELS - 1);
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      hold_r  <= hold_nxt;
      rot_r   <= rot_nxt;
    end
  end

endmodule

@@ rtl/sfd_fifo.sv @@
// two-entry queue of parsed words between front and back
// depends on sfd_pkg
module sfd_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sfd_pkg::sfd_item_t push_item,
  input  logic               pop,
  output sfd_pkg::sfd_item_t head,
  output logic               empty,
  output logic               full
);

  sfd_pkg::sfd_item_t                   slot_r [sfd_pkg::FIFO_DEPTH];
  logic [sfd_pkg::FIFO_PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [sfd_pkg::FIFO_CNT_W-1:0]       count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == sfd_pkg::FIFO_CNT_W'(sfd_pkg::FIFO_DEPTH));
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (push && !full ? 1'b1 : 1'b0) - (pop && !empty ? 1'b1 : 1'b0);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sfd_pkg::FIFO_CNT_W'(sfd_pkg::FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && !(pop && !empty)) |=> (count_r == $past(count_r) + 1'b1))
    else $error("push lost");

  a_pop_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !(push && !full)) |=> (count_r == $past(count_r) - 1'b1))
    else $error("pop lost");

endmodule

@@ rtl/sfd_back.sv @@
// back end: per-channel comb notch sequencer over a shared history memory
// depends on sfd_pkg
module sfd_back #(
  parameter int CHANNELS     = 8,
  parameter int FILTER_DELAY = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               empty,
  input  sfd_pkg::sfd_item_t head,
  output logic               pop,
  input  sfd_pkg::sfd_coef_t coef,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               out_item_kind,
  output logic [2:0]         out_channel,
  output logic signed [17:0] out_filtered_sample,
  output logic               out_check_ok
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W  = (FILTER_DELAY > 1) ? $clog2(FILTER_DELAY) : 1;
  localparam int DEPTH  = CHANNELS * FILTER_DELAY;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_ACC  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  sfd_pkg::sfd_item_t cur_r;
  logic [PTR_W-1:0]   ptr_r [CHANNELS];
  logic [CHANNELS-1:0] full_r;
  logic [ADDR_W-1:0]  addr_r, rd_addr;
  logic [40:0]        hist_mem [DEPTH];
  logic [40:0]        rd_data_r;
  logic [CH_W-1:0]    head_ch, cur_ch;
  logic signed [16:0] x_old;
  logic signed [23:0] y_old;
  logic signed [34:0] p0_r, p1_r;
  logic signed [41:0] p2_r;
  logic signed [35:0] ff_sum;
  logic signed [43:0] acc;
  logic signed [27:0] yq;
  logic signed [23:0] y_nxt, y_r;
  logic signed [24:0] t_round;
  logic signed [18:0] q_out;
  logic signed [17:0] sample_sat;
  logic               mem_we, mem_re, load_out;

  logic               out_valid_r;
  logic               out_kind_r;
  logic [2:0]         out_ch_r;
  logic signed [17:0] out_sample_r;
  logic               out_ok_r;

  assign head_ch = CH_W'(head.ch);
  assign cur_ch  = CH_W'(cur_r.ch);
  assign pop     = (state_r == S_IDLE) && !empty;
  assign mem_re  = pop && (head.kind == sfd_pkg::KIND_SAMPLE);
  assign mem_we  = (state_r == S_ACC);
  assign rd_addr = ADDR_W'(head_ch) * ADDR_W'(FILTER_DELAY) + ADDR_W'(ptr_r[head_ch]);
  assign load_out = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // entries not yet written since reset read as zero
  assign x_old = full_r[cur_ch] ? rd_data_r[40:24] : '0;
  assign y_old = full_r[cur_ch] ? rd_data_r[23:0]  : '0;

  assign ff_sum = {p0_r[34], p0_r} + {p1_r[34], p1_r};
  assign acc    = {{2{ff_sum[35]}}, ff_sum, 6'b0} - {{2{p2_r[41]}}, p2_r} + 44'sd32768;
  assign yq     = acc[43:16];
  assign y_nxt  = (yq[27:23] == {5{yq[23]}}) ? yq[23:0] :
                  (yq[27] ? 24'sh800000 : 24'sh7FFFFF);

  assign t_round    = {y_r[23], y_r} + 25'sd32;
  assign q_out      = t_round[24:6];
  assign sample_sat = (q_out[18] == q_out[17]) ? q_out[17:0] :
                      (q_out[18] ? 18'sh20000 : 18'sh1FFFF);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (!empty) begin
          state_nxt = (head.kind == sfd_pkg::KIND_SAMPLE) ? S_MUL : S_FIN;
        end
      end
      S_MUL:   state_nxt = S_ACC;
      S_ACC:   state_nxt = S_FIN;
      S_FIN: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[addr_r] <= {cur_r.x, y_nxt};
    end
    if (mem_re) begin
      rd_data_r <= hist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r  <= head;
      addr_r <= rd_addr;
    end
    if (state_r == S_MUL) begin
      p0_r <= coef.b_now * cur_r.x;
      p1_r <= coef.b_delay * x_old;
      p2_r <= coef.a_delay * y_old;
    end
    if (state_r == S_ACC) begin
      y_r <= y_nxt;
    end
    if (load_out) begin
      out_kind_r <= cur_r.kind;
      out_ok_r   <= (cur_r.kind == sfd_pkg::KIND_END) ? cur_r.ok : 1'b0;
      out_ch_r   <= (cur_r.kind == sfd_pkg::KIND_END) ? 3'd0 : 3'(cur_r.ch);
      out_sample_r <= (cur_r.kind == sfd_pkg::KIND_END) ? 18'sd0 : sample_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      full_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        ptr_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (mem_we) begin
        if (ptr_r[cur_ch] == PTR_W'(FILTER_DELAY - 1)) begin
          ptr_r[cur_ch]  <= '0;
          full_r[cur_ch] <= 1'b1;
        end else begin
          ptr_r[cur_ch] <= ptr_r[cur_ch] + 1'b1;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_item_kind       = out_kind_r;
  assign out_channel         = out_ch_r;
  assign out_filtered_sample = out_sample_r;
  assign out_check_ok        = out_ok_r;

  a_sample_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.kind == sfd_pkg::KIND_SAMPLE) |=> (state_r == S_MUL) ##1 (state_r == S_ACC))
    else $error("sample sequence broken");

  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == sfd_pkg::KIND_END) |-> (out_sample_r == 18'sd0 && out_ch_r == 3'd0))
    else $error("frame end word carries sample fields");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> (ptr_r[cur_ch] <= PTR_W'(FILTER_DELAY - 1)))
    else $error("history pointer out of range");

endmodule

@@ rtl/sync_frame_sample_deframer_filter_top.sv @@
// top level: config registers, front parser, word queue and filter back end
// depends on sfd_pkg, sfd_front, sfd_fifo, sfd_back
//
// Bytes are taken one per cycle while the two-word queue has room; header bytes and
// the high byte of each sample leave no word. Each sample word passes through the back
// end in order (history memory read, three parallel multiplies, accumulate and history
// write, round and output), and no new word is taken until the last one is output;
// a frame-end word skips the multiply and accumulate steps. The history memory holds
// CHANNELS*FILTER_DELAY entries of input and output history; a fill flag per channel
// makes unwritten history read as zero, so no clearing pass follows reset.
module sync_frame_sample_deframer_filter_top #(
  parameter int CHANNELS     = 8,
  parameter int FILTER_DELAY = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_item_kind,
  output logic [2:0]         out_channel,
  output logic signed [17:0] out_filtered_sample,
  output logic               out_check_ok,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [17:0]        cfg_data
);

  sfd_pkg::sfd_coef_t coef_r;
  logic [11:0]        offset_r;
  logic               push, pop, empty, full;
  sfd_pkg::sfd_item_t push_item, head;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b_now   <= sfd_pkg::B_NOW_RST;
      coef_r.b_delay <= sfd_pkg::B_DELAY_RST;
      coef_r.a_delay <= sfd_pkg::A_DELAY_RST;
      offset_r       <= sfd_pkg::OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfd_pkg::REG_B_NOW:   coef_r.b_now   <= cfg_data;
        sfd_pkg::REG_B_DELAY: coef_r.b_delay <= cfg_data;
        sfd_pkg::REG_A_DELAY: coef_r.a_delay <= cfg_data;
        sfd_pkg::REG_OFFSET:  offset_r       <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  sfd_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_rx_byte(in_rx_byte),
    .offset    (offset_r),
    .push      (push),
    .push_item (push_item)
  );

  sfd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  sfd_back #(
    .CHANNELS    (CHANNELS),
    .FILTER_DELAY(FILTER_DELAY)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .empty              (empty),
    .head               (head),
    .pop                (pop),
    .coef               (coef_r),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_item_kind      (out_item_kind),
    .out_channel        (out_channel),
    .out_filtered_sample(out_filtered_sample),
    .out_check_ok       (out_check_ok)
  );

endmodule
